>>> hw/rtl/timestamped_window_averager_top_assert.svh
// ----------------------------------------------------------------------------
// Timestamped window averager assertion macros
// Macros that state properties of the top level, checked at each clock edge.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_WINDOW_AVERAGER_TOP_ASSERT_SVH
`define TIMESTAMPED_WINDOW_AVERAGER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/twa_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped window averager package
// Shared constants, command codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package twa_pkg;

    localparam int WINDOW   = 64;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int TS_W     = 64;
    localparam int MET_W    = 32;
    localparam int LOSS_W   = 17;
    localparam int SUM_W    = MET_W + CNT_W;
    localparam int DCNT_W   = $clog2(SUM_W + 1);
    localparam int OFF_JIT  = 0;
    localparam int OFF_LOSS = MET_W;
    localparam int OFF_THR  = MET_W + LOSS_W;
    localparam int OFF_RTT  = 2 * MET_W + LOSS_W;
    localparam int OFF_TS   = 3 * MET_W + LOSS_W;
    localparam int MEM_W    = TS_W + 3 * MET_W + LOSS_W;

    localparam logic [TS_W-1:0] SIGN_MASK = {1'b1, {(TS_W-1){1'b0}}};
    localparam logic [TS_W-1:0] SPAN      = TS_W'(WINDOW - 1);

    localparam logic [1:0] M_RTT  = 2'd0;
    localparam logic [1:0] M_THR  = 2'd1;
    localparam logic [1:0] M_LOSS = 2'd2;
    localparam logic [1:0] M_JIT  = 2'd3;

    typedef enum logic [1:0] {
        CMD_INGEST  = 2'd0,
        CMD_NOTE    = 2'd1,
        CMD_SUMMARY = 2'd2,
        CMD_LOOKUP  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic       load;
        logic       advance;
        logic       range;
        logic       write;
        logic       rd_lookup;
        logic       walk_clr;
        logic       rd_walk;
        logic       acc;
        logic       div_start;
        logic [1:0] div_sel;
        logic       res_load;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic time_seen;
        logic walk_last;
        logic div_busy;
        logic count_zero;
    } t_dp_stat;

endpackage

>>> hw/rtl/twa_in_if.sv
// ----------------------------------------------------------------------------
// Timestamped window averager input channel
// Valid/ready channel that carries one command and its sample fields.
// ----------------------------------------------------------------------------
interface twa_in_if;
    logic                                        valid;
    logic                                        ready;
    logic [1:0]                                  command;
    logic signed [twa_pkg::TS_W-1:0]             timestamp;
    logic [twa_pkg::MET_W-1:0]                   sample_rtt;
    logic [twa_pkg::MET_W-1:0]                   sample_throughput;
    logic [twa_pkg::LOSS_W-1:0]                  sample_loss;
    logic [twa_pkg::MET_W-1:0]                   sample_jitter;

    modport source (
        output valid, command, timestamp, sample_rtt, sample_throughput,
               sample_loss, sample_jitter,
        input  ready
    );
    modport sink (
        input  valid, command, timestamp, sample_rtt, sample_throughput,
               sample_loss, sample_jitter,
        output ready
    );
endinterface

>>> hw/rtl/twa_out_if.sv
// ----------------------------------------------------------------------------
// Timestamped window averager result channel
// Valid/ready channel that carries one result per command.
// ----------------------------------------------------------------------------
interface twa_out_if;
    logic                            valid;
    logic                            ready;
    logic                            accepted;
    logic                            found;
    logic                            time_known;
    logic signed [twa_pkg::TS_W-1:0] newest_time;
    logic signed [twa_pkg::TS_W-1:0] oldest_time;
    logic [twa_pkg::CNT_W-1:0]       sample_count;
    logic [twa_pkg::MET_W-1:0]       rtt_value;
    logic [twa_pkg::MET_W-1:0]       throughput_value;
    logic [twa_pkg::LOSS_W-1:0]      loss_value;
    logic [twa_pkg::MET_W-1:0]       jitter_value;

    modport source (
        output valid, accepted, found, time_known, newest_time, oldest_time,
               sample_count, rtt_value, throughput_value, loss_value, jitter_value,
        input  ready
    );
    modport sink (
        input  valid, accepted, found, time_known, newest_time, oldest_time,
               sample_count, rtt_value, throughput_value, loss_value, jitter_value,
        output ready
    );
endinterface

>>> hw/rtl/timestamped_window_averager_top.sv
// ----------------------------------------------------------------------------
// Timestamped window averager
// Per-second ring of 64 metric slots with ingest, note-time, summary and
// lookup commands, one result transaction per command transaction.
// ----------------------------------------------------------------------------
// One command transaction is taken at a time and yields exactly one result
// transaction. Ingest passes through the advance, range and write states before
// its result, note time through the advance state, and lookup through one memory
// read of the registered slot memory. A summary with no time known goes straight
// to the result; otherwise the walk over the 64 slots reads each slot on the
// single read port of the slot memory, and the four averages use one shared
// radix-2 divider, skipped when no slot lies in the window. A finished result
// waits in the output register while the next command transaction is taken.
module timestamped_window_averager_top (
    input logic     i_clk,
    input logic     i_rst_n,
    twa_in_if.sink  i_in,
    twa_out_if.source o_out
);

    twa_pkg::t_dp_ctrl w_ctrl;
    twa_pkg::t_dp_stat w_stat;

    twa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_ctrl      (w_ctrl)
    );

    twa_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (w_ctrl),
        .o_stat              (w_stat),
        .i_command           (i_in.command),
        .i_timestamp         (i_in.timestamp),
        .i_sample_rtt        (i_in.sample_rtt),
        .i_sample_throughput (i_in.sample_throughput),
        .i_sample_loss       (i_in.sample_loss),
        .i_sample_jitter     (i_in.sample_jitter),
        .o_accepted          (o_out.accepted),
        .o_found             (o_out.found),
        .o_time_known        (o_out.time_known),
        .o_newest_time       (o_out.newest_time),
        .o_oldest_time       (o_out.oldest_time),
        .o_sample_count      (o_out.sample_count),
        .o_rtt_value         (o_out.rtt_value),
        .o_throughput_value  (o_out.throughput_value),
        .o_loss_value        (o_out.loss_value),
        .o_jitter_value      (o_out.jitter_value)
    );

`include "timestamped_window_averager_top_assert.svh"

    `TWA_ASSERT_NOW(a_acc_found_excl, o_out.valid, !(o_out.accepted && o_out.found), "accepted and found both set")
    `TWA_ASSERT_NOW(a_acc_known, o_out.valid && o_out.accepted, o_out.time_known, "accepted without known time")
    `TWA_ASSERT_NOW(a_empty_zero, o_out.valid && !o_out.found && (o_out.sample_count == 7'd0), (o_out.rtt_value == 32'd0) && (o_out.loss_value == 17'd0), "nonzero metrics without data")
    `TWA_ASSERT_NEXT(a_busy_after_take, i_in.valid && i_in.ready, !i_in.ready, "second transaction taken while busy")

endmodule

>>> hw/rtl/twa_dp.sv
// ----------------------------------------------------------------------------
// Timestamped window averager datapath
// Slot memory, newest-time tracking, window walk, shared divider and result.
// ----------------------------------------------------------------------------
module twa_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  twa_pkg::t_dp_ctrl                i_ctrl,
    output twa_pkg::t_dp_stat                o_stat,
    input  logic [1:0]                       i_command,
    input  logic [twa_pkg::TS_W-1:0]         i_timestamp,
    input  logic [twa_pkg::MET_W-1:0]        i_sample_rtt,
    input  logic [twa_pkg::MET_W-1:0]        i_sample_throughput,
    input  logic [twa_pkg::LOSS_W-1:0]       i_sample_loss,
    input  logic [twa_pkg::MET_W-1:0]        i_sample_jitter,
    output logic                             o_accepted,
    output logic                             o_found,
    output logic                             o_time_known,
    output logic [twa_pkg::TS_W-1:0]         o_newest_time,
    output logic [twa_pkg::TS_W-1:0]         o_oldest_time,
    output logic [twa_pkg::CNT_W-1:0]        o_sample_count,
    output logic [twa_pkg::MET_W-1:0]        o_rtt_value,
    output logic [twa_pkg::MET_W-1:0]        o_throughput_value,
    output logic [twa_pkg::LOSS_W-1:0]       o_loss_value,
    output logic [twa_pkg::MET_W-1:0]        o_jitter_value
);

    localparam int M_RTT_I  = int'(twa_pkg::M_RTT);
    localparam int M_THR_I  = int'(twa_pkg::M_THR);
    localparam int M_LOSS_I = int'(twa_pkg::M_LOSS);
    localparam int M_JIT_I  = int'(twa_pkg::M_JIT);

    logic [twa_pkg::MEM_W-1:0]  r_mem [twa_pkg::WINDOW];
    logic [twa_pkg::WINDOW-1:0] r_valid;
    logic                       r_seen;
    logic [twa_pkg::TS_W-1:0]   r_newest;
    twa_pkg::t_cmd              r_cmd;
    logic [twa_pkg::TS_W-1:0]   r_ts;
    logic [twa_pkg::MET_W-1:0]  r_rtt;
    logic [twa_pkg::MET_W-1:0]  r_thr;
    logic [twa_pkg::LOSS_W-1:0] r_loss;
    logic [twa_pkg::MET_W-1:0]  r_jit;
    logic [twa_pkg::TS_W-1:0]   r_lo;
    logic [twa_pkg::TS_W-1:0]   r_hi;
    logic                       r_ok;
    logic                       r_rd_valid;
    logic [twa_pkg::MEM_W-1:0]  r_rd_data;
    logic [twa_pkg::IDX_W-1:0]  r_walk;
    logic [twa_pkg::SUM_W-1:0]  r_sum [4];
    logic [twa_pkg::CNT_W-1:0]  r_count;
    logic [twa_pkg::MET_W-1:0]  r_avg [4];
    logic [twa_pkg::SUM_W-1:0]  r_quo;
    logic [twa_pkg::CNT_W:0]    r_rem;
    logic [twa_pkg::DCNT_W-1:0] r_dcnt;
    logic [1:0]                 r_dsel;

    logic                       r_res_accepted;
    logic                       r_res_found;
    logic                       r_res_known;
    logic [twa_pkg::TS_W-1:0]   r_res_newest;
    logic [twa_pkg::TS_W-1:0]   r_res_oldest;
    logic [twa_pkg::CNT_W-1:0]  r_res_count;
    logic [twa_pkg::MET_W-1:0]  r_res_rtt;
    logic [twa_pkg::MET_W-1:0]  r_res_thr;
    logic [twa_pkg::LOSS_W-1:0] r_res_loss;
    logic [twa_pkg::MET_W-1:0]  r_res_jit;

    logic [twa_pkg::TS_W-1:0]   n_newest;
    logic [twa_pkg::TS_W-1:0]   n_nb;
    logic [twa_pkg::TS_W-1:0]   n_lo;
    logic [twa_pkg::IDX_W-1:0]  n_idx;
    logic [twa_pkg::TS_W-1:0]   n_rd_ts;
    logic [twa_pkg::TS_W-1:0]   n_rd_sb;
    logic [twa_pkg::MET_W-1:0]  n_rd_rtt;
    logic [twa_pkg::MET_W-1:0]  n_rd_thr;
    logic [twa_pkg::LOSS_W-1:0] n_rd_loss;
    logic [twa_pkg::MET_W-1:0]  n_rd_jit;
    logic                       n_in_win;
    logic [twa_pkg::CNT_W:0]    n_rem_sh;
    logic [twa_pkg::CNT_W:0]    n_div;
    logic                       n_ge;
    logic [twa_pkg::CNT_W:0]    n_rem;
    logic [twa_pkg::SUM_W-1:0]  n_quo;
    logic                       n_is_sum;
    logic                       n_is_hit;

    always_comb begin
        if (!r_seen || ($signed(r_ts) > $signed(r_newest))) begin
            n_newest = r_ts;
        end else begin
            n_newest = r_newest;
        end
        n_nb = r_newest ^ twa_pkg::SIGN_MASK;
        if (n_nb >= twa_pkg::SPAN) begin
            n_lo = n_nb - twa_pkg::SPAN;
        end else begin
            n_lo = '0;
        end
        n_idx     = r_ts[twa_pkg::IDX_W-1:0];
        n_rd_ts   = r_rd_data[twa_pkg::OFF_TS +: twa_pkg::TS_W];
        n_rd_rtt  = r_rd_data[twa_pkg::OFF_RTT +: twa_pkg::MET_W];
        n_rd_thr  = r_rd_data[twa_pkg::OFF_THR +: twa_pkg::MET_W];
        n_rd_loss = r_rd_data[twa_pkg::OFF_LOSS +: twa_pkg::LOSS_W];
        n_rd_jit  = r_rd_data[twa_pkg::OFF_JIT +: twa_pkg::MET_W];
        n_rd_sb   = n_rd_ts ^ twa_pkg::SIGN_MASK;
        n_in_win  = r_rd_valid && (n_rd_sb >= r_lo) && (n_rd_sb <= r_hi);
        n_rem_sh  = {r_rem[twa_pkg::CNT_W-1:0], r_quo[twa_pkg::SUM_W-1]};
        n_div     = {1'b0, r_count};
        n_ge      = (n_rem_sh >= n_div);
        n_rem     = n_ge ? (n_rem_sh - n_div) : n_rem_sh;
        n_quo     = {r_quo[twa_pkg::SUM_W-2:0], n_ge};
        n_is_sum  = (r_cmd == twa_pkg::CMD_SUMMARY) && r_seen;
        n_is_hit  = (r_cmd == twa_pkg::CMD_LOOKUP) && r_rd_valid && (n_rd_ts == r_ts);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 1'b0;
            r_newest <= '0;
            r_valid  <= '0;
            r_dcnt   <= '0;
        end else begin
            if (i_ctrl.advance) begin
                r_seen   <= 1'b1;
                r_newest <= n_newest;
            end
            if (i_ctrl.write && r_ok) begin
                r_valid[n_idx] <= 1'b1;
            end
            if (i_ctrl.div_start) begin
                r_dcnt <= twa_pkg::DCNT_W'(twa_pkg::SUM_W);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && r_ok) begin
            r_mem[n_idx] <= {r_ts, r_rtt, r_thr, r_loss, r_jit};
        end
        if (i_ctrl.rd_lookup) begin
            r_rd_data  <= r_mem[n_idx];
            r_rd_valid <= r_valid[n_idx];
        end else if (i_ctrl.rd_walk) begin
            r_rd_data  <= r_mem[r_walk];
            r_rd_valid <= r_valid[r_walk];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= twa_pkg::t_cmd'(i_command);
            r_ts   <= i_timestamp;
            r_rtt  <= i_sample_rtt;
            r_thr  <= i_sample_throughput;
            r_loss <= i_sample_loss;
            r_jit  <= i_sample_jitter;
        end
        if (i_ctrl.range) begin
            r_lo <= n_lo;
            r_hi <= n_nb;
            r_ok <= ((r_ts ^ twa_pkg::SIGN_MASK) >= n_lo);
        end
        if (i_ctrl.walk_clr) begin
            r_walk  <= '0;
            r_count <= '0;
            for (int k = 0; k < 4; k++) begin
                r_sum[k] <= '0;
            end
        end else if (i_ctrl.acc) begin
            r_walk <= r_walk + 1'b1;
            if (n_in_win) begin
                r_count      <= r_count + 1'b1;
                r_sum[M_RTT_I] <= r_sum[M_RTT_I] + twa_pkg::SUM_W'(n_rd_rtt);
                r_sum[M_THR_I] <= r_sum[M_THR_I] + twa_pkg::SUM_W'(n_rd_thr);
                r_sum[M_LOSS_I] <= r_sum[M_LOSS_I] + twa_pkg::SUM_W'(n_rd_loss);
                r_sum[M_JIT_I] <= r_sum[M_JIT_I] + twa_pkg::SUM_W'(n_rd_jit);
            end
        end
        if (i_ctrl.div_start) begin
            r_quo  <= r_sum[i_ctrl.div_sel];
            r_rem  <= '0;
            r_dsel <= i_ctrl.div_sel;
        end else if (r_dcnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            if (r_dcnt == twa_pkg::DCNT_W'(1)) begin
                r_avg[r_dsel] <= n_quo[twa_pkg::MET_W-1:0];
            end
        end
        if (i_ctrl.res_load) begin
            r_res_accepted <= (r_cmd == twa_pkg::CMD_INGEST) && r_ok;
            r_res_found    <= n_is_hit;
            r_res_known    <= r_seen;
            r_res_newest   <= n_is_sum ? r_newest : '0;
            r_res_oldest   <= n_is_sum ? (r_lo ^ twa_pkg::SIGN_MASK) : '0;
            r_res_count    <= n_is_sum ? r_count : '0;
            if (n_is_sum && (r_count != '0)) begin
                r_res_rtt  <= r_avg[M_RTT_I];
                r_res_thr  <= r_avg[M_THR_I];
                r_res_loss <= r_avg[M_LOSS_I][twa_pkg::LOSS_W-1:0];
                r_res_jit  <= r_avg[M_JIT_I];
            end else if (n_is_hit) begin
                r_res_rtt  <= n_rd_rtt;
                r_res_thr  <= n_rd_thr;
                r_res_loss <= n_rd_loss;
                r_res_jit  <= n_rd_jit;
            end else begin
                r_res_rtt  <= '0;
                r_res_thr  <= '0;
                r_res_loss <= '0;
                r_res_jit  <= '0;
            end
        end
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.time_seen  = r_seen;
    assign o_stat.walk_last  = (r_walk == twa_pkg::IDX_W'(twa_pkg::WINDOW - 1));
    assign o_stat.div_busy   = (r_dcnt != '0);
    assign o_stat.count_zero = (r_count == '0);

    assign o_accepted         = r_res_accepted;
    assign o_found            = r_res_found;
    assign o_time_known       = r_res_known;
    assign o_newest_time      = r_res_newest;
    assign o_oldest_time      = r_res_oldest;
    assign o_sample_count     = r_res_count;
    assign o_rtt_value        = r_res_rtt;
    assign o_throughput_value = r_res_thr;
    assign o_loss_value       = r_res_loss;
    assign o_jitter_value     = r_res_jit;

endmodule

>>> hw/rtl/twa_ctrl.sv
// ----------------------------------------------------------------------------
// Timestamped window averager controller
// Sequences each command through the datapath and owns the channel handshakes.
// ----------------------------------------------------------------------------
module twa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  twa_pkg::t_dp_stat i_stat,
    output twa_pkg::t_dp_ctrl o_ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADV,
        S_RANGE,
        S_WRITE,
        S_LKRD,
        S_SRANGE,
        S_WRD,
        S_WACC,
        S_DCHK,
        S_DIV,
        S_DWAIT,
        S_FIN
    } t_state;

    t_state     r_state;
    logic       r_out_valid;
    logic [1:0] r_k;
    logic       n_res_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign n_res_load  = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_ctrl         = '0;
        o_ctrl.div_sel = r_k;
        case (r_state)
            S_IDLE:   o_ctrl.load      = i_in_valid;
            S_ADV:    o_ctrl.advance   = 1'b1;
            S_RANGE:  o_ctrl.range     = 1'b1;
            S_WRITE:  o_ctrl.write     = 1'b1;
            S_LKRD:   o_ctrl.rd_lookup = 1'b1;
            S_SRANGE: begin
                o_ctrl.range    = 1'b1;
                o_ctrl.walk_clr = 1'b1;
            end
            S_WRD:    o_ctrl.rd_walk   = 1'b1;
            S_WACC:   o_ctrl.acc       = 1'b1;
            S_DIV:    o_ctrl.div_start = 1'b1;
            S_FIN:    o_ctrl.res_load  = n_res_load;
            default:  o_ctrl.load      = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (n_res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (i_stat.cmd)
                        twa_pkg::CMD_INGEST:  r_state <= S_ADV;
                        twa_pkg::CMD_NOTE:    r_state <= S_ADV;
                        twa_pkg::CMD_SUMMARY: r_state <= i_stat.time_seen ? S_SRANGE : S_FIN;
                        twa_pkg::CMD_LOOKUP:  r_state <= S_LKRD;
                        default:              r_state <= S_FIN;
                    endcase
                end
                S_ADV: begin
                    r_state <= (i_stat.cmd == twa_pkg::CMD_INGEST) ? S_RANGE : S_FIN;
                end
                S_RANGE:  r_state <= S_WRITE;
                S_WRITE:  r_state <= S_FIN;
                S_LKRD:   r_state <= S_FIN;
                S_SRANGE: r_state <= S_WRD;
                S_WRD:    r_state <= S_WACC;
                S_WACC: begin
                    r_state <= i_stat.walk_last ? S_DCHK : S_WRD;
                end
                S_DCHK: begin
                    r_k     <= '0;
                    r_state <= i_stat.count_zero ? S_FIN : S_DIV;
                end
                S_DIV:    r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (!i_stat.div_busy) begin
                        if (r_k == twa_pkg::M_JIT) begin
                            r_state <= S_FIN;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_FIN: begin
                    if (n_res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> tb/timestamped_window_averager_top_tb.sv
// ----------------------------------------------------------------------------
// Timestamped window averager testbench
// Drives random and directed command transactions with random gaps and
// stalls, predicts each result from a behavioral copy of the slot ring and
// compares every result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamped_window_averager_top_tb;

    typedef struct {
        twa_pkg::t_cmd                      cmd;
        logic signed [twa_pkg::TS_W-1:0]    ts;
        logic [twa_pkg::MET_W-1:0]          rtt;
        logic [twa_pkg::MET_W-1:0]          thr;
        logic [twa_pkg::LOSS_W-1:0]         loss;
        logic [twa_pkg::MET_W-1:0]          jit;
    } t_command;

    typedef struct {
        logic                               accepted;
        logic                               found;
        logic                               time_known;
        logic signed [twa_pkg::TS_W-1:0]    newest;
        logic signed [twa_pkg::TS_W-1:0]    oldest;
        logic [twa_pkg::CNT_W-1:0]          count;
        logic [twa_pkg::MET_W-1:0]          rtt;
        logic [twa_pkg::MET_W-1:0]          thr;
        logic [twa_pkg::LOSS_W-1:0]         loss;
        logic [twa_pkg::MET_W-1:0]          jit;
    } t_result;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk;
    logic i_rst_n;

    twa_in_if  cmd_ch ();
    twa_out_if res_ch ();

    timestamped_window_averager_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source)
    );

    t_command pending_cmds[$];
    t_result  expected_results[$];
    int       error_count;
    int       cycle_count;
    bit       stimulus_done;
    int       hold_off_cycles;
    bit       in_taken;
    bit       out_taken;

    // Behavioral copy of the ring.
    bit                                 seen;
    logic [twa_pkg::TS_W-1:0]           latest_stamp;
    bit                                 ring_valid[twa_pkg::WINDOW];
    logic [twa_pkg::TS_W-1:0]           ring_ts[twa_pkg::WINDOW];
    logic [twa_pkg::MET_W-1:0]          ring_rtt[twa_pkg::WINDOW];
    logic [twa_pkg::MET_W-1:0]          ring_thr[twa_pkg::WINDOW];
    logic [twa_pkg::LOSS_W-1:0]         ring_loss[twa_pkg::WINDOW];
    logic [twa_pkg::MET_W-1:0]          ring_jit[twa_pkg::WINDOW];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [twa_pkg::TS_W-1:0] order_key(logic [twa_pkg::TS_W-1:0] v);
        return v ^ twa_pkg::SIGN_MASK;
    endfunction

    function automatic int ring_index(logic [twa_pkg::TS_W-1:0] v);
        return int'(v[twa_pkg::IDX_W-1:0]);
    endfunction

    function automatic logic [twa_pkg::TS_W-1:0] window_start_key();
        logic [twa_pkg::TS_W-1:0] nb;
        nb = order_key(latest_stamp);
        return (nb >= twa_pkg::SPAN) ? nb - twa_pkg::SPAN : '0;
    endfunction

    function automatic void track_time(logic [twa_pkg::TS_W-1:0] v);
        if (!seen || order_key(v) > order_key(latest_stamp)) latest_stamp = v;
        seen = 1'b1;
    endfunction

    function automatic t_result predict_result(t_command c);
        t_result r;
        logic [twa_pkg::TS_W-1:0] lo, hi, sk;
        logic [63:0] s_rtt, s_thr, s_loss, s_jit, n;
        int i;
        r = '{default: '0};
        case (c.cmd)
            twa_pkg::CMD_INGEST: begin
                track_time(c.ts);
                if (order_key(c.ts) >= window_start_key()) begin
                    i = ring_index(c.ts);
                    ring_valid[i] = 1'b1;
                    ring_ts[i] = c.ts;
                    ring_rtt[i] = c.rtt;
                    ring_thr[i] = c.thr;
                    ring_loss[i] = c.loss;
                    ring_jit[i] = c.jit;
                    r.accepted = 1'b1;
                end
            end
            twa_pkg::CMD_NOTE: track_time(c.ts);
            twa_pkg::CMD_SUMMARY: begin
                if (seen) begin
                    lo = window_start_key();
                    hi = order_key(latest_stamp);
                    s_rtt = 0; s_thr = 0; s_loss = 0; s_jit = 0; n = 0;
                    for (i = 0; i < twa_pkg::WINDOW; i++) begin
                        sk = order_key(ring_ts[i]);
                        if (ring_valid[i] && sk >= lo && sk <= hi) begin
                            s_rtt += ring_rtt[i];
                            s_thr += ring_thr[i];
                            s_loss += ring_loss[i];
                            s_jit += ring_jit[i];
                            n++;
                        end
                    end
                    r.newest = latest_stamp;
                    r.oldest = lo ^ twa_pkg::SIGN_MASK;
                    r.count = n[twa_pkg::CNT_W-1:0];
                    if (n != 0) begin
                        r.rtt = twa_pkg::MET_W'(s_rtt / n);
                        r.thr = twa_pkg::MET_W'(s_thr / n);
                        r.loss = twa_pkg::LOSS_W'(s_loss / n);
                        r.jit = twa_pkg::MET_W'(s_jit / n);
                    end
                end
            end
            default: begin
                i = ring_index(c.ts);
                if (ring_valid[i] && ring_ts[i] == c.ts) begin
                    r.found = 1'b1;
                    r.rtt = ring_rtt[i];
                    r.thr = ring_thr[i];
                    r.loss = ring_loss[i];
                    r.jit = ring_jit[i];
                end
            end
        endcase
        r.time_known = seen;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic t_command make_cmd(twa_pkg::t_cmd cmd, logic [63:0] ts);
        t_command c;
        c.cmd = cmd;
        c.ts = ts;
        c.rtt = $urandom();
        c.thr = $urandom();
        c.loss = twa_pkg::LOSS_W'(($urandom_range(0, 3) == 0) ? $urandom()
                                                                 : $urandom_range(0, 100000));
        c.jit = $urandom();
        return c;
    endfunction

    // Command driver.
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            gap_left <= $urandom_range(0, 19);
        end else if (cmd_ch.valid && !in_taken) begin
        end else begin
            if (in_taken) void'(pending_cmds.pop_front());
            if (pending_cmds.size() > 0 && gap_left == 0) begin
                t_command c;
                c = pending_cmds[0];
                cmd_ch.valid <= 1'b1;
                cmd_ch.command <= c.cmd;
                cmd_ch.timestamp <= c.ts;
                cmd_ch.sample_rtt <= c.rtt;
                cmd_ch.sample_throughput <= c.thr;
                cmd_ch.sample_loss <= c.loss;
                cmd_ch.sample_jitter <= c.jit;
                gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            end else begin
                cmd_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // Predict on acceptance and check results.
    int stall_left;
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && cmd_ch.valid && cmd_ch.ready;
        out_taken <= i_rst_n && res_ch.valid && res_ch.ready;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (cmd_ch.valid && cmd_ch.ready) begin
                t_command c;
                c.cmd = twa_pkg::t_cmd'(cmd_ch.command);
                c.ts = cmd_ch.timestamp;
                c.rtt = cmd_ch.sample_rtt;
                c.thr = cmd_ch.sample_throughput;
                c.loss = cmd_ch.sample_loss;
                c.jit = cmd_ch.sample_jitter;
                expected_results.push_back(predict_result(c));
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (res_ch.accepted !== e.accepted)
                        report_mismatch("accepted", res_ch.accepted, e.accepted);
                    if (res_ch.found !== e.found)
                        report_mismatch("found", res_ch.found, e.found);
                    if (res_ch.time_known !== e.time_known)
                        report_mismatch("time_known", res_ch.time_known, e.time_known);
                    if (res_ch.newest_time !== e.newest)
                        report_mismatch("newest_time", res_ch.newest_time, e.newest);
                    if (res_ch.oldest_time !== e.oldest)
                        report_mismatch("oldest_time", res_ch.oldest_time, e.oldest);
                    if (res_ch.sample_count !== e.count)
                        report_mismatch("sample_count", res_ch.sample_count, e.count);
                    if (res_ch.rtt_value !== e.rtt)
                        report_mismatch("rtt_value", res_ch.rtt_value, e.rtt);
                    if (res_ch.throughput_value !== e.thr)
                        report_mismatch("throughput_value", res_ch.throughput_value, e.thr);
                    if (res_ch.loss_value !== e.loss)
                        report_mismatch("loss_value", res_ch.loss_value, e.loss);
                    if (res_ch.jitter_value !== e.jit)
                        report_mismatch("jitter_value", res_ch.jitter_value, e.jit);
                end
            end
        end
    end

    // Result receiver with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left <= 0;
        end else if (hold_off_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (out_taken) begin
            if ($urandom_range(0, 2) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left <= $urandom_range(0, 19);
            end
        end else if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    initial begin
        logic [63:0] base, ts;
        int k, r;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = twa_pkg::CMD_INGEST;
        cmd_ch.timestamp = '0;
        cmd_ch.sample_rtt = '0;
        cmd_ch.sample_throughput = '0;
        cmd_ch.sample_loss = '0;
        cmd_ch.sample_jitter = '0;
        res_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        seen = 0;
        latest_stamp = '0;
        for (k = 0; k < twa_pkg::WINDOW; k++) ring_valid[k] = 0;

        // Directed: summary with no time known, then edges of the fields.
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_SUMMARY, 0));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_LOOKUP, 5));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, 64'h8000_0000_0000_0000));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, 64'h8000_0000_0000_0005));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_SUMMARY, 0));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, -64'sd3));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_LOOKUP, -64'sd3));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, -64'sd67));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_NOTE, 100));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, 36));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, 37));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_SUMMARY, 0));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_NOTE, 50));
        pending_cmds[$].rtt = '1; pending_cmds[$].thr = '1;
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, 100));
        pending_cmds[$].rtt = '1; pending_cmds[$].thr = '1;
        pending_cmds[$].loss = '1; pending_cmds[$].jit = '1;
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, 99));
        pending_cmds[$].rtt = '1; pending_cmds[$].thr = '1;
        pending_cmds[$].loss = '1; pending_cmds[$].jit = '1;
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, 98));
        pending_cmds[$].rtt = '0; pending_cmds[$].thr = '0;
        pending_cmds[$].loss = '0; pending_cmds[$].jit = '0;
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_SUMMARY, 0));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_LOOKUP, 36));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, 64'h7FFF_FFFF_FFFF_FFFF));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFBF));
        pending_cmds.push_back(make_cmd(twa_pkg::CMD_SUMMARY, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random: mostly a moving clock near a base with samples around it.
        for (r = 0; r < 18; r++) begin
            case ($urandom_range(0, 3))
                0: base = {$urandom(), $urandom()};
                1: base = 64'h8000_0000_0000_0000 + $urandom_range(0, 200);
                2: base = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 200);
                default: base = -64'sd150 + 64'($urandom_range(0, 300));
            endcase
            for (k = 0; k < 100; k++) begin
                if ($urandom_range(0, 3) == 0) base += $urandom_range(0, 3);
                ts = base - $urandom_range(0, 80);
                if ($urandom_range(0, 40) == 0) ts = {$urandom(), $urandom()};
                case ($urandom_range(0, 15))
                    0, 1: pending_cmds.push_back(make_cmd(twa_pkg::CMD_NOTE, ts));
                    2: pending_cmds.push_back(make_cmd(twa_pkg::CMD_SUMMARY, ts));
                    3, 4, 5, 6: pending_cmds.push_back(make_cmd(twa_pkg::CMD_LOOKUP, ts));
                    default: pending_cmds.push_back(make_cmd(twa_pkg::CMD_INGEST, ts));
                endcase
            end
            if (r == 4) begin
                while (pending_cmds.size() > 40) @(posedge i_clk);
                hold_off_cycles = 400;
            end
        end

        while (pending_cmds.size() != 0 || cmd_ch.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end
endmodule

>>> timestamped_window_averager_top.f
+incdir+hw/rtl
hw/rtl/twa_pkg.sv
hw/rtl/twa_in_if.sv
hw/rtl/twa_out_if.sv
hw/rtl/twa_dp.sv
hw/rtl/twa_ctrl.sv
hw/rtl/timestamped_window_averager_top.sv
tb/timestamped_window_averager_top_tb.sv
